// ----- src/scsm_pkg.sv -----
`default_nettype none

package scsm_pkg;

    // fixed field widths
    localparam int LEVEL_W     = 10;
    localparam int PHASE_W     = 6;
    localparam int LG_W        = 3;
    localparam int SHIFT_W     = 3;
    localparam int ENTRY_W     = 17;
    localparam int ROM_IDX_W   = 5;
    localparam int PWM_TOP_W   = 16;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 3;

    // defaults for top level parameters
    localparam int PWM_TOP_DEFAULT        = 1023;
    localparam int MAX_MICROSTEPS_DEFAULT = 64;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MICROSTEP_ENABLE = 1'b0,
        REG_MICROSTEPS_LOG2  = 1'b1
    } cfg_reg_t;

    // command codes on the op field
    typedef enum logic {
        OP_STEP = 1'b0,
        OP_OFF  = 1'b1
    } op_t;

    localparam logic [LG_W-1:0] LG_MIN   = 3'd2;
    localparam logic [LG_W-1:0] LG_RESET = 3'd4;

    // classified command as queued by the front
    typedef struct packed {
        logic                off;
        logic                dir;
        logic [PHASE_W-1:0]  mask;
        logic [SHIFT_W-1:0]  shift;
    } cmd_t;

    // one microstep beat from the sequencer to the wave datapath
    typedef struct packed {
        logic                valid;
        logic                off;
        logic                last;
        logic [PHASE_W-1:0]  k;
        logic [PHASE_W-1:0]  p;
    } beat_t;

    // quarter wave of sin in Q1.16, 64ths of a cycle, last entry full scale
    function automatic logic [ENTRY_W-1:0] quarter_sine(input logic [ROM_IDX_W-1:0] idx);
        logic [ENTRY_W-1:0] v;
        case (idx)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd6423;
            5'd2:    v = 17'd12785;
            5'd3:    v = 17'd19024;
            5'd4:    v = 17'd25079;
            5'd5:    v = 17'd30893;
            5'd6:    v = 17'd36409;
            5'd7:    v = 17'd41575;
            5'd8:    v = 17'd46340;
            5'd9:    v = 17'd50660;
            5'd10:   v = 17'd54491;
            5'd11:   v = 17'd57797;
            5'd12:   v = 17'd60547;
            5'd13:   v = 17'd62714;
            5'd14:   v = 17'd64276;
            5'd15:   v = 17'd65220;
            5'd16:   v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- src/scsm_if.sv -----
`default_nettype none

interface scsm_cmd_if;
    logic valid;
    logic ready;
    logic op;
    logic direction;

    modport source (output valid, output op, output direction, input ready);
    modport sink   (input valid, input op, input direction, output ready);
endinterface

interface scsm_res_if;
    logic                          valid;
    logic                          ready;
    logic [scsm_pkg::LEVEL_W-1:0]  coil_a_positive;
    logic [scsm_pkg::LEVEL_W-1:0]  coil_a_negative;
    logic [scsm_pkg::LEVEL_W-1:0]  coil_b_positive;
    logic [scsm_pkg::LEVEL_W-1:0]  coil_b_negative;
    logic [scsm_pkg::PHASE_W-1:0]  phase_index;
    logic                          last;

    modport source (output valid, output coil_a_positive, output coil_a_negative,
                    output coil_b_positive, output coil_b_negative,
                    output phase_index, output last, input ready);
    modport sink   (input valid, input coil_a_positive, input coil_a_negative,
                    input coil_b_positive, input coil_b_negative,
                    input phase_index, input last, output ready);
endinterface

`default_nettype wire

// ----- src/sine_cosine_microstep_generator.sv -----
`default_nettype none

// sine/cosine microstep generator for a two-coil stepper on four pwm channels.
// each command beat on cmd is a step (one full electrical cycle) or an off.
// a step sweeps M = 2**microsteps_log2 microsteps (log2 clamped to 2 and to
// floor(log2(MAX_MICROSTEPS))) and emits M result beats, phase_index 0..M-1
// forward or M-1..0 backward; coil a follows cos and coil b follows sin of
// 2*pi*k/M, each split into a positive and a negative level of
// floor(|value| * PWM_TOP), last marks the final beat. an off emits one
// all-zero beat with last set; a step while microstep_enable is 0 is taken and
// yields nothing. results leave at one beat per cycle while res is ready; the
// sequencer output drives a two-register path (lookup, then scale into the
// output register), and an accepted command is first registered in the queue.
// a two-entry command queue lets cmd keep taking commands while res stalls,
// until it is full. configuration is written through cfg_we/cfg_index/cfg_data;
// the user must do so only while idle, the block does not enforce it.
module sine_cosine_microstep_generator #(
    parameter int PWM_TOP        = scsm_pkg::PWM_TOP_DEFAULT,
    parameter int MAX_MICROSTEPS = scsm_pkg::MAX_MICROSTEPS_DEFAULT
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    scsm_cmd_if.sink                            cmd,
    scsm_res_if.source                          res,
    input  wire                                 cfg_we,
    input  wire [scsm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [scsm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // front to queue
    logic               q_push;
    scsm_pkg::cmd_t     q_data;
    logic               q_full;

    // queue to sequencer
    logic               q_pop;
    logic               q_not_empty;
    scsm_pkg::cmd_t     q_head;

    // sequencer to wave datapath, advance is the shared stall
    scsm_pkg::beat_t    beat;
    logic               advance;

    // front: config registers and command classification
    scsm_front #(
        .MAX_MICROSTEPS (MAX_MICROSTEPS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    // decoupling queue
    scsm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // microstep sequencer, one beat per cycle while advance is high
    scsm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .advance     (advance),
        .beat        (beat)
    );

    // rom lookup, pwm scaling and output register
    scsm_wave #(
        .PWM_TOP (PWM_TOP)
    ) u_wave (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (beat),
        .advance (advance),
        .res     (res)
    );

endmodule

`default_nettype wire

// ----- src/scsm_front.sv -----
`default_nettype none

module scsm_front #(
    parameter int MAX_MICROSTEPS = scsm_pkg::MAX_MICROSTEPS_DEFAULT
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    scsm_cmd_if.sink                            cmd,
    input  wire                                 cfg_we,
    input  wire [scsm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [scsm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                 q_full,
    output logic                                q_push,
    output scsm_pkg::cmd_t                      q_data
);

    // largest log2 that fits MAX_MICROSTEPS, never below the minimum
    localparam int LG_FIT = $clog2(MAX_MICROSTEPS + 1) - 1;
    localparam logic [scsm_pkg::LG_W-1:0] LG_MAX =
        scsm_pkg::LG_W'((LG_FIT < 2) ? 2 : LG_FIT);

    logic                         enable_reg;
    logic [scsm_pkg::LG_W-1:0]    lg_reg;
    logic [scsm_pkg::LG_W-1:0]    lg_eff;
    logic                         accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            lg_reg     <= scsm_pkg::LG_RESET;
        end
        else if (cfg_we)
        begin
            case (scsm_pkg::cfg_reg_t'(cfg_index))
                scsm_pkg::REG_MICROSTEP_ENABLE: enable_reg <= cfg_data[0];
                scsm_pkg::REG_MICROSTEPS_LOG2:  lg_reg     <= cfg_data;
                default:                        ;
            endcase
        end
    end

    always_comb
    begin
        if (lg_reg < scsm_pkg::LG_MIN)
            lg_eff = scsm_pkg::LG_MIN;
        else if (lg_reg > LG_MAX)
            lg_eff = LG_MAX;
        else
            lg_eff = lg_reg;
    end

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && !q_full;

    // a step while disabled is taken and dropped
    assign q_push = accept && ((cmd.op == scsm_pkg::OP_OFF) || enable_reg);

    always_comb
    begin
        q_data.off   = (cmd.op == scsm_pkg::OP_OFF);
        q_data.dir   = cmd.direction;
        q_data.mask  = scsm_pkg::PHASE_W'((7'd1 << lg_eff) - 7'd1);
        q_data.shift = scsm_pkg::SHIFT_W'(4'd6 - {1'b0, lg_eff});
    end

endmodule

`default_nettype wire

// ----- src/scsm_queue.sv -----
`default_nettype none

module scsm_queue (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  scsm_pkg::cmd_t   push_data,
    input  wire              pop,
    output logic             full,
    output logic             not_empty,
    output scsm_pkg::cmd_t   head
);

    localparam int DEPTH = scsm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    scsm_pkg::cmd_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- src/scsm_seq.sv -----
`default_nettype none

module scsm_seq (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              q_not_empty,
    input  scsm_pkg::cmd_t   q_head,
    output logic             q_pop,
    input  wire              advance,
    output scsm_pkg::beat_t  beat
);

    logic                            active_reg, active_next;
    logic                            dir_reg, dir_next;
    logic [scsm_pkg::PHASE_W-1:0]    mask_reg, mask_next;
    logic [scsm_pkg::SHIFT_W-1:0]    shift_reg, shift_next;
    logic [scsm_pkg::PHASE_W-1:0]    i_reg, i_next;
    logic [scsm_pkg::SHIFT_W-1:0]    shift_cur;

    always_comb
    begin
        active_next = active_reg;
        dir_next    = dir_reg;
        mask_next   = mask_reg;
        shift_next  = shift_reg;
        i_next      = i_reg;
        q_pop       = 1'b0;
        beat.valid  = 1'b0;
        beat.off    = 1'b0;
        beat.last   = 1'b0;
        beat.k      = '0;
        shift_cur   = shift_reg;

        if (active_reg)
        begin
            beat.valid = 1'b1;
            beat.k     = dir_reg ? (mask_reg & ~i_reg) : i_reg;
            beat.last  = (i_reg == mask_reg);
            if (advance)
            begin
                i_next = i_reg + 1'b1;
                if (beat.last)
                    active_next = 1'b0;
            end
        end
        else if (q_not_empty)
        begin
            // first beat straight from the queue head, no bubble
            beat.valid = 1'b1;
            shift_cur  = q_head.shift;
            if (q_head.off)
            begin
                beat.off  = 1'b1;
                beat.last = 1'b1;
            end
            else
            begin
                beat.k = q_head.dir ? q_head.mask : '0;
            end
            if (advance)
            begin
                q_pop = 1'b1;
                if (!q_head.off)
                begin
                    active_next = 1'b1;
                    dir_next    = q_head.dir;
                    mask_next   = q_head.mask;
                    shift_next  = q_head.shift;
                    i_next      = scsm_pkg::PHASE_W'(1);
                end
            end
        end

        // phase in 64ths of a cycle
        beat.p = beat.k << shift_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 1'b0;
        else
            active_reg <= active_next;
    end

    always_ff @(posedge clk)
    begin
        dir_reg   <= dir_next;
        mask_reg  <= mask_next;
        shift_reg <= shift_next;
        i_reg     <= i_next;
    end

endmodule

`default_nettype wire

// ----- src/scsm_wave.sv -----
`default_nettype none

module scsm_wave #(
    parameter int PWM_TOP = scsm_pkg::PWM_TOP_DEFAULT
) (
    input  wire              clk,
    input  wire              rst_n,
    input  scsm_pkg::beat_t  beat,
    output logic             advance,
    scsm_res_if.source       res
);

    localparam int PROD_W = scsm_pkg::ENTRY_W + scsm_pkg::PWM_TOP_W;
    localparam logic [PROD_W-1:0] TOP = PROD_W'(PWM_TOP);

    logic [scsm_pkg::PHASE_W-1:0]    p_cos;
    logic [scsm_pkg::ENTRY_W-1:0]    sin_entry;
    logic [scsm_pkg::ENTRY_W-1:0]    cos_entry;

    logic                            a_valid_reg;
    logic [scsm_pkg::ENTRY_W-1:0]    sin_entry_reg;
    logic [scsm_pkg::ENTRY_W-1:0]    cos_entry_reg;
    logic                            sin_neg_reg;
    logic                            cos_neg_reg;
    logic [scsm_pkg::PHASE_W-1:0]    k_reg;
    logic                            last_reg;

    logic [PROD_W-1:0]               sin_prod;
    logic [PROD_W-1:0]               cos_prod;
    logic [scsm_pkg::LEVEL_W-1:0]    sin_level;
    logic [scsm_pkg::LEVEL_W-1:0]    cos_level;

    logic                            out_valid_reg;
    logic [scsm_pkg::LEVEL_W-1:0]    ap_reg, an_reg, bp_reg, bn_reg;
    logic [scsm_pkg::PHASE_W-1:0]    phase_reg;
    logic                            out_last_reg;

    function automatic logic [scsm_pkg::ENTRY_W-1:0] fold(input logic [scsm_pkg::PHASE_W-1:0] p);
        logic [scsm_pkg::ROM_IDX_W-1:0] idx;
        idx = {1'b0, p[3:0]};
        // odd quadrants run the quarter wave backward
        if (p[4])
            idx = 5'd16 - idx;
        return scsm_pkg::quarter_sine(idx);
    endfunction

    assign advance = !out_valid_reg || res.ready;

    // stage a: rom lookup
    assign p_cos     = beat.p + scsm_pkg::PHASE_W'(16);
    assign sin_entry = beat.off ? '0 : fold(beat.p);
    assign cos_entry = beat.off ? '0 : fold(p_cos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg   <= beat.valid;
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sin_entry_reg <= sin_entry;
            cos_entry_reg <= cos_entry;
            sin_neg_reg   <= beat.p[5];
            cos_neg_reg   <= p_cos[5];
            k_reg         <= beat.k;
            last_reg      <= beat.last;
        end
    end

    // stage b: scale to pwm range, truncate, split by sign
    assign sin_prod  = PROD_W'(sin_entry_reg) * TOP;
    assign cos_prod  = PROD_W'(cos_entry_reg) * TOP;
    assign sin_level = sin_prod[16 +: scsm_pkg::LEVEL_W];
    assign cos_level = cos_prod[16 +: scsm_pkg::LEVEL_W];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ap_reg       <= cos_neg_reg ? '0 : cos_level;
            an_reg       <= cos_neg_reg ? cos_level : '0;
            bp_reg       <= sin_neg_reg ? '0 : sin_level;
            bn_reg       <= sin_neg_reg ? sin_level : '0;
            phase_reg    <= k_reg;
            out_last_reg <= last_reg;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.coil_a_positive = ap_reg;
    assign res.coil_a_negative = an_reg;
    assign res.coil_b_positive = bp_reg;
    assign res.coil_b_negative = bn_reg;
    assign res.phase_index     = phase_reg;
    assign res.last            = out_last_reg;

endmodule

`default_nettype wire

// ----- src/scsm_checker.sv -----
`default_nettype none

module scsm_checker (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 res_valid,
    input  wire                                 res_ready,
    input  wire [scsm_pkg::LEVEL_W-1:0]         res_ap,
    input  wire [scsm_pkg::LEVEL_W-1:0]         res_an,
    input  wire [scsm_pkg::LEVEL_W-1:0]         res_bp,
    input  wire [scsm_pkg::LEVEL_W-1:0]         res_bn,
    input  wire [scsm_pkg::PHASE_W-1:0]         res_phase,
    input  wire                                 res_last
);

    // stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_ap) && $stable(res_an)
            && $stable(res_bp) && $stable(res_bn) && $stable(res_phase)
            && $stable(res_last))
        else $error("result beat changed while stalled");

    // a coil is never driven on both halves
    a_coil_a_split: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_ap == '0) || (res_an == '0))
        else $error("coil a driven on both halves");

    a_coil_b_split: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_bp == '0) || (res_bn == '0))
        else $error("coil b driven on both halves");

    // phase zero has no sine component
    a_phase_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_phase == '0) |-> (res_bp == '0) && (res_bn == '0))
        else $error("sine level nonzero at phase zero");

endmodule

bind sine_cosine_microstep_generator scsm_checker u_scsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_ap    (res.coil_a_positive),
    .res_an    (res.coil_a_negative),
    .res_bp    (res.coil_b_positive),
    .res_bn    (res.coil_b_negative),
    .res_phase (res.phase_index),
    .res_last  (res.last)
);

`default_nettype wire
